>>> sv/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned StatusW = 2;

  // operation codes
  localparam logic OpEnqueue = 1'b0;
  localparam logic OpDequeue = 1'b1;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  // one stored entry
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [DataW-1:0] prio;
  } entry_t;

  // what a cell hands to the cell behind it
  typedef struct packed {
    logic   less;  // occupied and lower priority than the incoming item
    entry_t ent;
  } link_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   enq;   // insert the incoming entry
    logic   deq;   // shift everything one place toward the head
    entry_t ent;   // incoming entry
  } cmd_t;

endpackage

>>> sv/spq_cell.sv
// one slot of the shift-register queue
module spq_cell import spq_pkg::*; (
  input  logic   clk_i,
  input  logic   occ_i,    // this slot holds a live entry
  input  cmd_t   cmd_i,
  input  link_t  left_i,   // neighbour nearer the head
  input  entry_t right_i,  // neighbour nearer the tail
  output link_t  link_o
);

  entry_t ent_q, ent_d;
  logic   less;

  assign less = occ_i && ($signed(ent_q.prio) < $signed(cmd_i.ent.prio));

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.deq) begin
      ent_d = right_i;
    end else if (cmd_i.enq) begin
      if (left_i.less) begin
        ent_d = left_i.ent;
      end else if (less || !occ_i) begin
        ent_d = cmd_i.ent;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign link_o.less = less;
  assign link_o.ent  = ent_q;

endmodule

>>> sv/sorted_priority_queue_core.sv
// sorted priority queue: top level with the cell chain, fill count and result register
// latency: the result of an accepted item is registered and appears in the output register in the cycle after it
// throughput: one item per cycle while in_stall_o is low; every cell compares and shifts in the same cycle
// input stall rises only while a finished result waits and the output is stalled
// reset clears the fill count and the result valid flag; slot contents are not reset
// and are never read before they are written
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic signed [DataW-1:0] data_i,
  input  logic signed [DataW-1:0] priority_req_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] out_data_o,
  output logic signed [DataW-1:0] out_priority_o,
  output logic [StatusW-1:0]      status_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam logic [CountW-1:0] Full = CountW'(CAPACITY);

  // fill count: slots below it are live, head at slot zero
  logic [CountW-1:0] count_q, count_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_data_q, out_data_d;
  logic [DataW-1:0]   out_prio_q, out_prio_d;
  status_e            status_q, status_d;

  logic   accept;
  logic   is_full, is_empty;
  cmd_t   cmd;
  link_t  links [CAPACITY];

  // the result register frees itself when its item is taken this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == Full);
  assign is_empty = (count_q == '0);

  // broadcast command; rejected operations leave the chain untouched
  assign cmd.enq      = accept && (operation_i == OpEnqueue) && !is_full;
  assign cmd.deq      = accept && (operation_i == OpDequeue) && !is_empty;
  assign cmd.ent.data = data_i;
  assign cmd.ent.prio = priority_req_i;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t  left;
    entry_t right;
    logic   occ;

    assign occ = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = links[i-1];
    end

    // the tail slot has no neighbour behind it, so it keeps its own (now dead) content
    if (i == CAPACITY - 1) begin : g_tail
      assign right = links[i].ent;
    end else begin : g_inner
      assign right = links[i+1].ent;
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .occ_i   (occ),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  // fill count and result formation
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_prio_d  = out_prio_q;
    status_d    = status_q;
    if (cmd.enq) begin
      count_d = count_q + CountW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CountW'(1);
    end
    if (accept) begin
      out_valid_d = 1'b1;
      if (operation_i == OpDequeue) begin
        if (is_empty) begin
          // underflow returns all ones
          out_data_d = '1;
          out_prio_d = '1;
          status_d   = StUnderflow;
        end else begin
          out_data_d = links[0].ent.data;
          out_prio_d = links[0].ent.prio;
          status_d   = StOk;
        end
      end else begin
        out_data_d = '0;
        out_prio_d = '0;
        status_d   = is_full ? StOverflow : StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_prio_q <= out_prio_d;
    status_q   <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = $signed(out_data_q);
  assign out_priority_o = $signed(out_prio_q);
  assign status_o       = status_q;

endmodule
